// ----- design/mbrtu_pkg.sv -----
// Shared types, constants and the CRC-16 step for the Modbus RTU FC04 responder.
// No dependencies; every other design file but mbrtu_ifs.sv imports this package.
`default_nettype none

package mbrtu_pkg;

    // Frame layout and protocol constants
    localparam int unsigned FRAME_BYTES = 8;
    localparam int unsigned COUNT_W     = 4;            // holds 0..9
    localparam logic [COUNT_W-1:0] COUNT_SAT  = 4'd9;
    localparam logic [COUNT_W-1:0] COUNT_FULL = 4'd8;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0]  REPLY_BYTE_COUNT = 8'h04;
    localparam logic [15:0] REQ_REG_COUNT = 16'h0002;

    // Input register numbers that are answered
    localparam logic [15:0] REG_VOLTAGE = 16'h0000;
    localparam logic [15:0] REG_CURRENT = 16'h0006;
    localparam logic [15:0] REG_POWER   = 16'h000C;
    localparam logic [15:0] REG_ENERGY  = 16'h001A;

    // Word select codes carried from front to back
    localparam logic [1:0] SEL_VOLTAGE = 2'd0;
    localparam logic [1:0] SEL_CURRENT = 2'd1;
    localparam logic [1:0] SEL_POWER   = 2'd2;
    localparam logic [1:0] SEL_ENERGY  = 2'd3;

    // APB register map
    localparam int unsigned PADDR_W = 5;
    localparam logic [2:0] CFG_SLAVE   = 3'd0;
    localparam logic [2:0] CFG_VOLTAGE = 3'd1;
    localparam logic [2:0] CFG_CURRENT = 3'd2;
    localparam logic [2:0] CFG_POWER   = 3'd3;
    localparam logic [2:0] CFG_ENERGY  = 3'd4;

    localparam logic [7:0]  RST_SLAVE   = 8'd1;
    localparam logic [31:0] RST_VOLTAGE = 32'h4366_8000;
    localparam logic [31:0] RST_CURRENT = 32'h3F9D_70A4;
    localparam logic [31:0] RST_POWER   = 32'h438D_999A;
    localparam logic [31:0] RST_ENERGY  = 32'h4145_70A4;

    // Job queue between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = 1;
    localparam int unsigned Q_CW    = 2;                // holds 0..Q_DEPTH

    typedef struct packed {
        logic       valid;
        logic [1:0] sel;
    } t_push;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] head;
    } t_q_stat;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [31:0] voltage_word;
        logic [31:0] current_word;
        logic [31:0] power_word;
        logic [31:0] energy_word;
    } t_cfg;

    // One byte of the reflected Modbus CRC-16
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/mbrtu_ifs.sv -----
// Valid/ready channel interfaces: received request bytes and transmitted reply bytes.
// Self-contained; used by the responder modules.
`default_nettype none

interface mbrtu_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source(output valid, output rx_byte, output frame_end, input ready);
    modport sink(input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mbrtu_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       reply_last;

    modport source(output valid, output tx_byte, output reply_last, input ready);
    modport sink(input valid, input tx_byte, input reply_last, output ready);
endinterface

`default_nettype wire

// ----- design/mbrtu_front.sv -----
// Request front end: stores frame bytes, counts them, runs the CRC and judges each frame.
// Depends on mbrtu_pkg and mbrtu_rx_if; pushes one job per answered frame.
`default_nettype none

module mbrtu_front import mbrtu_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mbrtu_rx_if.sink      i_rx,
    input  logic [7:0]    i_slave_address,
    input  logic          i_q_full,
    output t_push         o_push
);

    logic [7:0]         r_store [FRAME_BYTES];
    logic [COUNT_W-1:0] r_count;
    logic [15:0]        r_crc;

    logic [COUNT_W-1:0] n_count;
    logic [15:0]        n_crc;
    logic               accept;
    logic               frame_ok;
    logic               reg_hit;
    logic [1:0]         sel;
    logic [15:0]        req_reg;
    logic [15:0]        req_cnt;

    assign i_rx.ready = !i_q_full;
    assign accept     = i_rx.valid && i_rx.ready;

    // Running count and CRC including the byte now offered
    always_comb begin
        n_count = (r_count < COUNT_SAT) ? r_count + 4'd1 : r_count;
        n_crc   = crc_byte(r_crc, i_rx.rx_byte);
    end

    // Decode the requested register
    assign req_reg = {r_store[2], r_store[3]};
    assign req_cnt = {r_store[4], r_store[5]};

    always_comb begin
        reg_hit = 1'b1;
        sel     = SEL_VOLTAGE;
        unique case (req_reg)
            REG_VOLTAGE: sel = SEL_VOLTAGE;
            REG_CURRENT: sel = SEL_CURRENT;
            REG_POWER:   sel = SEL_POWER;
            REG_ENERGY:  sel = SEL_ENERGY;
            default:     reg_hit = 1'b0;
        endcase
    end

    // Full judgement on the flagged byte; store bytes 0..5 are all in place by then
    assign frame_ok = (n_count == COUNT_FULL) && (n_crc == 16'h0000)
                   && (r_store[0] == i_slave_address)
                   && (r_store[1] == FUNC_READ_INPUT)
                   && (req_cnt == REQ_REG_COUNT) && reg_hit;

    assign o_push.valid = accept && i_rx.frame_end && frame_ok;
    assign o_push.sel   = sel;

    // Frame store: the first eight bytes of a frame, CRC bytes included
    always_ff @(posedge i_clk) begin
        if (accept && (r_count < COUNT_FULL)) begin
            r_store[r_count[2:0]] <= i_rx.rx_byte;
        end
    end

    // Count and CRC restart at every frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
        end else if (accept) begin
            if (i_rx.frame_end) begin
                r_count <= '0;
                r_crc   <= CRC_INIT;
            end else begin
                r_count <= n_count;
                r_crc   <= n_crc;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/mbrtu_queue.sv -----
// Two-entry job queue between the request front end and the reply back end.
// Depends on mbrtu_pkg for the job and status types.
`default_nettype none

module mbrtu_queue import mbrtu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output t_q_stat o_stat
);

    logic [1:0]      r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_CW-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.head  = r_mem[r_rptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.sel;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push.valid) r_wptr <= r_wptr + 1'b1;
            if (i_pop)        r_rptr <= r_rptr + 1'b1;
            unique case ({i_push.valid, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/mbrtu_back.sv -----
// Reply back end: turns each queued job into the nine reply bytes with their CRC.
// Depends on mbrtu_pkg and mbrtu_tx_if; pops jobs from mbrtu_queue.
`default_nettype none

module mbrtu_back import mbrtu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_q_stat     i_q,
    output logic        o_pop,
    mbrtu_tx_if.source  o_tx
);

    // Reply byte positions
    localparam logic [3:0] IDX_ADDR  = 4'd0;
    localparam logic [3:0] IDX_FUNC  = 4'd1;
    localparam logic [3:0] IDX_BCNT  = 4'd2;
    localparam logic [3:0] IDX_W3    = 4'd3;
    localparam logic [3:0] IDX_W2    = 4'd4;
    localparam logic [3:0] IDX_W1    = 4'd5;
    localparam logic [3:0] IDX_W0    = 4'd6;
    localparam logic [3:0] IDX_CRC_L = 4'd7;
    localparam logic [3:0] IDX_CRC_H = 4'd8;

    logic        r_busy;
    logic [3:0]  r_idx;
    logic [1:0]  r_sel;
    logic [15:0] r_crc;
    logic        r_tx_valid;
    logic [7:0]  r_tx_byte;
    logic        r_tx_last;

    logic        load;
    logic        emit;
    logic [3:0]  idx;
    logic [1:0]  sel;
    logic [15:0] crc;
    logic [31:0] word;
    logic [7:0]  n_byte;
    logic [15:0] n_crc;

    assign o_tx.valid      = r_tx_valid;
    assign o_tx.tx_byte    = r_tx_byte;
    assign o_tx.reply_last = r_tx_last;

    // Output register takes a byte when empty or being drained
    assign load  = !r_tx_valid || o_tx.ready;
    assign emit  = load && (r_busy || !i_q.empty);
    assign o_pop = load && !r_busy && !i_q.empty;

    // A fresh job starts at byte 0 with the CRC preset
    assign idx = r_busy ? r_idx : IDX_ADDR;
    assign sel = r_busy ? r_sel : i_q.head;
    assign crc = r_busy ? r_crc : CRC_INIT;

    always_comb begin
        unique case (sel)
            SEL_VOLTAGE: word = i_cfg.voltage_word;
            SEL_CURRENT: word = i_cfg.current_word;
            SEL_POWER:   word = i_cfg.power_word;
            SEL_ENERGY:  word = i_cfg.energy_word;
            default:     word = i_cfg.voltage_word;
        endcase
    end

    // Byte for the current position; CRC covers the first seven
    always_comb begin
        unique case (idx)
            IDX_ADDR:  n_byte = i_cfg.slave_address;
            IDX_FUNC:  n_byte = FUNC_READ_INPUT;
            IDX_BCNT:  n_byte = REPLY_BYTE_COUNT;
            IDX_W3:    n_byte = word[31:24];
            IDX_W2:    n_byte = word[23:16];
            IDX_W1:    n_byte = word[15:8];
            IDX_W0:    n_byte = word[7:0];
            IDX_CRC_L: n_byte = crc[7:0];
            IDX_CRC_H: n_byte = crc[15:8];
            default:   n_byte = crc[15:8];
        endcase
        n_crc = (idx < IDX_CRC_L) ? crc_byte(crc, n_byte) : crc;
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_tx_byte <= n_byte;
            r_tx_last <= (idx == IDX_CRC_H);
            r_sel     <= sel;
            r_crc     <= n_crc;
            r_idx     <= idx + 4'd1;
        end
    end

    // Reply sequencing control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_tx_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_busy     <= (idx != IDX_CRC_H);
                r_tx_valid <= 1'b1;
            end else if (o_tx.ready) begin
                r_tx_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/modbus_rtu_input_register_responder.sv -----
// Modbus RTU read-input-registers responder: top level with APB configuration.
// Usage:
//   i_rx carries received bytes (rx_byte, frame_end on the last byte of a frame),
//   o_tx carries reply bytes (tx_byte, reply_last on the ninth byte); both are
//   valid/ready, a word moves when valid and ready are high at a clock edge.
//   The APB port holds slave_address (0x00), voltage_word (0x04), current_word
//   (0x08), power_word (0x0C) and energy_word (0x10); pready is always high.
// Throughput: one received word per cycle unless the job queue is full; a reply leaves
//   at one word per cycle while o_tx.ready holds, paced by the single output register.
// Reply path: with the back end free, an accepted frame_end word pushes a job into the
//   queue, and the back end then loads the first reply word into the output register.
// Answered frames wait in a two-entry job queue; i_rx.ready drops only while that
//   queue is full, so a stalled receiver on o_tx eventually back-pressures i_rx.
//   A stalled reply word holds its value until taken.
// Reset (i_rst_n low, synchronous) clears the queue, the CRC and byte count, the
//   output valid, and returns the registers to their defaults. Dropped frames
//   give no output at all.
`default_nettype none

module modbus_rtu_input_register_responder import mbrtu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mbrtu_rx_if.sink           i_rx,
    mbrtu_tx_if.source         o_tx,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg    r_cfg;
    t_push   push;
    t_q_stat q_stat;
    logic    pop;
    logic    cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_W-1:2];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address <= RST_SLAVE;
            r_cfg.voltage_word  <= RST_VOLTAGE;
            r_cfg.current_word  <= RST_CURRENT;
            r_cfg.power_word    <= RST_POWER;
            r_cfg.energy_word   <= RST_ENERGY;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                CFG_SLAVE:   r_cfg.slave_address <= pwdata[7:0];
                CFG_VOLTAGE: r_cfg.voltage_word  <= pwdata;
                CFG_CURRENT: r_cfg.current_word  <= pwdata;
                CFG_POWER:   r_cfg.power_word    <= pwdata;
                CFG_ENERGY:  r_cfg.energy_word   <= pwdata;
                default:     ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (cfg_idx)
            CFG_SLAVE:   prdata = {24'h000000, r_cfg.slave_address};
            CFG_VOLTAGE: prdata = r_cfg.voltage_word;
            CFG_CURRENT: prdata = r_cfg.current_word;
            CFG_POWER:   prdata = r_cfg.power_word;
            CFG_ENERGY:  prdata = r_cfg.energy_word;
            default:     prdata = '0;
        endcase
    end

    mbrtu_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx            (i_rx),
        .i_slave_address (r_cfg.slave_address),
        .i_q_full        (q_stat.full),
        .o_push          (push)
    );

    mbrtu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_stat  (q_stat)
    );

    mbrtu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_q     (q_stat),
        .o_pop   (pop),
        .o_tx    (o_tx)
    );

endmodule

`default_nettype wire

// ----- design/mbrtu_checker.sv -----
// Port-level checks for the responder's reply channel, bound to the top level.
// Depends on mbrtu_pkg; sees only top-level ports.
`default_nettype none

module mbrtu_checker import mbrtu_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_tx_valid,
    input logic       i_tx_ready,
    input logic [7:0] i_tx_byte,
    input logic       i_tx_last
);

    logic [3:0] r_pos;
    logic       tx_acc;

    assign tx_acc = i_tx_valid && i_tx_ready;

    // Position of the next reply word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (tx_acc) begin
            r_pos <= i_tx_last ? 4'd0 : r_pos + 4'd1;
        end
    end

    // Reset leaves no reply word pending
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_tx_valid)
        else $error("reply valid after reset");

    // A stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tx_valid && !i_tx_ready |=> i_tx_valid && $stable(i_tx_byte) && $stable(i_tx_last))
        else $error("stalled reply word changed");

    // The last flag falls exactly on the ninth word
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_acc |-> (i_tx_last == (r_pos == 4'd8)))
        else $error("reply_last not on ninth word");

    // Function code and byte count words
    a_func: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_acc && (r_pos == 4'd1 || r_pos == 4'd2) |-> i_tx_byte == FUNC_READ_INPUT)
        else $error("bad function or byte count word");

endmodule

bind modbus_rtu_input_register_responder mbrtu_checker u_mbrtu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_tx_valid (o_tx.valid),
    .i_tx_ready (o_tx.ready),
    .i_tx_byte  (o_tx.tx_byte),
    .i_tx_last  (o_tx.reply_last)
);

`default_nettype wire

// ----- sim/tb_modbus_rtu_input_register_responder.sv -----
// Self-checking testbench for the Modbus RTU read-input-registers responder.
// Needs mbrtu_pkg, the mbrtu_rx_if/mbrtu_tx_if interfaces and the responder top level.
// Drives request frames with random gaps and stalls, and checks every reply word.

module tb_modbus_rtu_input_register_responder import mbrtu_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 16;    // covers a dropped frame still in flight
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moved on any port
    localparam int RANDOM_ITEMS   = 392;
    localparam int PHASE_ITEMS    = 98;
    localparam int MAX_GAP        = 6;
    localparam int REPLY_WORDS    = 9;
    localparam logic [2:0] CFG_UNMAPPED = 3'd5;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       reply_last;
    } t_reply_word;

    // Directed rows: dropped frames are typed in, answered ones come from the predictor
    typedef enum logic {ROW_DROPPED, ROW_PREDICTED} t_row_check;

    typedef struct packed {
        logic [63:0] head;       // byte 0 in the top bits
        logic [3:0]  n_head;
        logic        crc_tail;
        logic [3:0]  n_extra;    // zero bytes after the CRC
        t_row_check  check;
    } t_dir_frame;

    typedef enum int {
        FK_GOOD, FK_BAD_ADDR, FK_BAD_FUNC, FK_BAD_COUNT, FK_BAD_REG,
        FK_BAD_CRC, FK_SHORT, FK_LONG, FK_NOISE
    } t_frame_kind;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    mbrtu_rx_if rx_ch();
    mbrtu_tx_if tx_ch();

    modbus_rtu_input_register_responder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_tx    (tx_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor state and register shadow
    t_cfg        cfg_shadow;
    logic [7:0]  rx_store [FRAME_BYTES];
    logic [3:0]  rx_count;
    logic [15:0] rx_crc;
    t_reply_word reply_due [$];
    logic [7:0]  frame_buf [$];

    bit calm;               // no idling on either side
    int mismatches    = 0;
    int rx_items      = 0;
    int frames_sent   = 0;
    int reply_count   = 0;
    int words_checked = 0;
    int quiet_cycles  = 0;
    int settings_used = 1;

    t_dir_frame directed_frames [4];

    // Bit-serial form of the reflected CRC-16
    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i]) begin
                r = {1'b0, r[15:1]} ^ CRC_POLY;
            end else begin
                r = {1'b0, r[15:1]};
            end
        end
        return r;
    endfunction

    function automatic t_dir_frame frame_row(input logic [63:0] head, input int n_head,
                                             input bit crc_tail, input int n_extra,
                                             input t_row_check check);
        t_dir_frame f;
        f.head     = head;
        f.n_head   = n_head[3:0];
        f.crc_tail = crc_tail;
        f.n_extra  = n_extra[3:0];
        f.check    = check;
        return f;
    endfunction

    function automatic logic [31:0] shadow_value(input logic [2:0] idx);
        case (idx)
            CFG_SLAVE:   return {24'h0, cfg_shadow.slave_address};
            CFG_VOLTAGE: return cfg_shadow.voltage_word;
            CFG_CURRENT: return cfg_shadow.current_word;
            CFG_POWER:   return cfg_shadow.power_word;
            CFG_ENERGY:  return cfg_shadow.energy_word;
            default:     return 32'h0;
        endcase
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] random_register();
        case ($urandom_range(0, 3))
            0:       return REG_VOLTAGE;
            1:       return REG_CURRENT;
            2:       return REG_POWER;
            default: return REG_ENERGY;
        endcase
    endfunction

    // Track one accepted request byte; queue the nine reply words when a frame is answered
    task automatic predict_reply(input logic [7:0] b, input logic eof);
        logic        hit;
        logic [15:0] reg_no;
        logic [15:0] reg_cnt;
        logic [15:0] crc;
        logic [31:0] word;
        logic [7:0]  reply [REPLY_WORDS];
        t_reply_word w;
        if (rx_count < COUNT_FULL) begin
            rx_store[rx_count[2:0]] = b;
        end
        if (rx_count < COUNT_SAT) begin
            rx_count = rx_count + 4'd1;
        end
        rx_crc = crc16_next(rx_crc, b);
        if (eof) begin
            hit = (rx_count == COUNT_FULL) && (rx_crc == 16'h0000);
            rx_count = '0;
            rx_crc   = CRC_INIT;
            word     = '0;
            if (hit) begin
                hit = (rx_store[0] == cfg_shadow.slave_address)
                   && (rx_store[1] == FUNC_READ_INPUT);
            end
            if (hit) begin
                reg_no  = {rx_store[2], rx_store[3]};
                reg_cnt = {rx_store[4], rx_store[5]};
                hit = (reg_cnt == REQ_REG_COUNT);
                case (reg_no)
                    REG_VOLTAGE: word = cfg_shadow.voltage_word;
                    REG_CURRENT: word = cfg_shadow.current_word;
                    REG_POWER:   word = cfg_shadow.power_word;
                    REG_ENERGY:  word = cfg_shadow.energy_word;
                    default:     hit = 1'b0;
                endcase
            end
            if (hit) begin
                reply[0] = cfg_shadow.slave_address;
                reply[1] = FUNC_READ_INPUT;
                reply[2] = REPLY_BYTE_COUNT;
                reply[3] = word[31:24];
                reply[4] = word[23:16];
                reply[5] = word[15:8];
                reply[6] = word[7:0];
                crc = CRC_INIT;
                for (int i = 0; i < 7; i++) begin
                    crc = crc16_next(crc, reply[i]);
                end
                reply[7] = crc[7:0];
                reply[8] = crc[15:8];
                for (int i = 0; i < REPLY_WORDS; i++) begin
                    w.tx_byte    = reply[i];
                    w.reply_last = (i == REPLY_WORDS - 1);
                    reply_due.push_back(w);
                end
                reply_count++;
            end
        end
    endtask

    // One request word: optional gap, then hold valid until ready
    task automatic send_word(input logic [7:0] b, input logic eof);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid     <= 1'b1;
        rx_ch.rx_byte   <= b;
        rx_ch.frame_end <= eof;
        do @(posedge i_clk); while (!rx_ch.ready);
        predict_reply(b, eof);
        rx_items++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) begin
            send_word(frame_buf[i], i == frame_buf.size() - 1);
        end
        frames_sent++;
    endtask

    task automatic append_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_buf[i]) begin
            c = crc16_next(c, frame_buf[i]);
        end
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endtask

    task automatic build_request(input logic [7:0] addr, input logic [7:0] func,
                                 input logic [15:0] reg_no, input logic [15:0] count);
        frame_buf.delete();
        frame_buf.push_back(addr);
        frame_buf.push_back(func);
        frame_buf.push_back(reg_no[15:8]);
        frame_buf.push_back(reg_no[7:0]);
        frame_buf.push_back(count[15:8]);
        frame_buf.push_back(count[7:0]);
        append_crc();
    endtask

    // Mostly well-formed requests, the rest broken in one way or pure noise
    task automatic send_random_frame();
        int          r;
        int          n;
        t_frame_kind kind;
        logic [7:0]  addr;
        logic [7:0]  func;
        logic [7:0]  tmp;
        logic [15:0] reg_no;
        logic [15:0] count;
        r      = $urandom_range(0, 19);
        kind   = (r < 12) ? FK_GOOD : t_frame_kind'(r - 11);
        addr   = cfg_shadow.slave_address;
        func   = FUNC_READ_INPUT;
        count  = REQ_REG_COUNT;
        reg_no = random_register();
        case (kind)
            FK_BAD_ADDR:  addr = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
            FK_BAD_FUNC:  func = 8'($urandom_range(0, 255));
            FK_BAD_COUNT: count = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                                        : 16'($urandom_range(0, 4));
            FK_BAD_REG:   reg_no = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                                         : reg_no + 16'd1;
            default: ;
        endcase
        build_request(addr, func, reg_no, count);
        case (kind)
            FK_BAD_CRC: begin
                n = $urandom_range(0, FRAME_BYTES - 1);
                frame_buf[n] = frame_buf[n] ^ (8'h01 << $urandom_range(0, 7));
            end
            FK_SHORT: begin
                n = $urandom_range(1, FRAME_BYTES - 1);
                while (frame_buf.size() > n) tmp = frame_buf.pop_back();
            end
            FK_LONG: begin
                repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom_range(0, 255)));
            end
            FK_NOISE: begin
                frame_buf.delete();
                repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        send_frame();
    endtask

    // APB transfer; psel stays high for a following transfer, penable drops
    task automatic apb_access(input logic wr, input logic [2:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel   <= 1'b1;
        pwrite <= wr;
        paddr  <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        penable <= 1'b0;
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            CFG_SLAVE:   cfg_shadow.slave_address = value[7:0];
            CFG_VOLTAGE: cfg_shadow.voltage_word  = value;
            CFG_CURRENT: cfg_shadow.current_word  = value;
            CFG_POWER:   cfg_shadow.power_word    = value;
            CFG_ENERGY:  cfg_shadow.energy_word   = value;
            default: ;
        endcase
    endtask

    // Read back every register against the shadow, then end the APB burst
    task automatic check_registers();
        logic [31:0] got;
        for (int i = CFG_SLAVE; i <= CFG_ENERGY; i++) begin
            apb_access(1'b0, i[2:0], 32'h0, got);
            if (got !== shadow_value(i[2:0])) begin
                mismatches++;
                $display("%0t ns: register %0d read expected %08h, got %08h",
                         $time, i, shadow_value(i[2:0]), got);
            end
        end
        psel <= 1'b0;
    endtask

    task automatic reconfigure(input int phase);
        case (phase)
            0: begin
                // top address, upper data bits must be dropped
                cfg_write(CFG_SLAVE, 32'hA5C3_E1F7);
                cfg_write(CFG_VOLTAGE, 32'h0000_0000);
                cfg_write(CFG_CURRENT, 32'hFFFF_FFFF);
                cfg_write(CFG_POWER, $urandom);
                cfg_write(CFG_ENERGY, $urandom);
                cfg_write(CFG_UNMAPPED, $urandom);
            end
            1: begin
                cfg_write(CFG_SLAVE, 32'd1);
                cfg_write(CFG_VOLTAGE, 32'hFFFF_FFFF);
                cfg_write(CFG_CURRENT, 32'h0000_0000);
                cfg_write(CFG_POWER, random_word());
                cfg_write(CFG_ENERGY, random_word());
            end
            default: begin
                cfg_write(CFG_SLAVE, $urandom_range(1, 247));
                cfg_write(CFG_VOLTAGE, random_word());
                cfg_write(CFG_CURRENT, random_word());
                cfg_write(CFG_POWER, random_word());
                cfg_write(CFG_ENERGY, random_word());
            end
        endcase
        check_registers();
        settings_used++;
    endtask

    // Request side must already be released
    task automatic wait_idle();
        while (reply_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Reply side: random stall per word
    initial begin : reply_sink
        int stall;
        tx_ch.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                tx_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            tx_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!tx_ch.valid);
        end
    end

    // Reply check and watchdog
    always @(posedge i_clk) begin : reply_check
        t_reply_word due;
        if (i_rst_n && tx_ch.valid && tx_ch.ready) begin
            words_checked++;
            if (reply_due.size() == 0) begin
                mismatches++;
                $display("%0t ns: reply word with none expected, got %02h/last %0b",
                         $time, tx_ch.tx_byte, tx_ch.reply_last);
            end else begin
                due = reply_due.pop_front();
                if (tx_ch.tx_byte !== due.tx_byte || tx_ch.reply_last !== due.reply_last) begin
                    mismatches++;
                    $display("%0t ns: reply word expected %02h/last %0b, got %02h/last %0b",
                             $time, due.tx_byte, due.reply_last,
                             tx_ch.tx_byte, tx_ch.reply_last);
                end
            end
        end
        if (!i_rst_n || (rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready) || psel)
        begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: timeout, no word moved for %0d cycles, %0d reply words owed",
                         $time, WATCHDOG_LIMIT, reply_due.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin : stimulus
        int phase;
        int rnd_base;
        int replies_before;
        rx_ch.valid     = 1'b0;
        rx_ch.rx_byte   = 8'h00;
        rx_ch.frame_end = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = 32'h0;
        calm            = 1'b0;
        cfg_shadow      = '{RST_SLAVE, RST_VOLTAGE, RST_CURRENT, RST_POWER, RST_ENERGY};
        rx_count        = '0;
        rx_crc          = CRC_INIT;
        foreach (rx_store[i]) rx_store[i] = 8'h00;

        // request for register 0 with reset values, a one-byte frame of all ones,
        // a valid request with one byte too many, then a clean request for energy
        directed_frames[0] = frame_row(64'h0104_0000_0002_0000, 6, 1'b1, 0, ROW_PREDICTED);
        directed_frames[1] = frame_row(64'hFF00_0000_0000_0000, 1, 1'b0, 0, ROW_DROPPED);
        directed_frames[2] = frame_row(64'h0104_0006_0002_0000, 6, 1'b1, 1, ROW_DROPPED);
        directed_frames[3] = frame_row(64'h0104_001A_0002_0000, 6, 1'b1, 0, ROW_PREDICTED);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_registers();

        // Directed part
        foreach (directed_frames[r]) begin
            frame_buf.delete();
            for (int i = 0; i < directed_frames[r].n_head; i++) begin
                frame_buf.push_back(directed_frames[r].head[63 - 8 * i -: 8]);
            end
            if (directed_frames[r].crc_tail) begin
                append_crc();
            end
            repeat (directed_frames[r].n_extra) frame_buf.push_back(8'h00);
            replies_before = reply_count;
            send_frame();
            if (directed_frames[r].check == ROW_DROPPED && reply_count != replies_before) begin
                mismatches++;
                $display("%0t ns: directed frame %0d expected no reply, predictor answers",
                         $time, r);
            end
        end

        // Random part, one register setting per phase
        rnd_base = rx_items;
        phase = 0;
        while (rx_items - rnd_base < RANDOM_ITEMS) begin
            rx_ch.valid <= 1'b0;
            wait_idle();
            reconfigure(phase);
            calm = (phase == 1);
            replies_before = rx_items;
            while (rx_items - replies_before < PHASE_ITEMS) send_random_frame();
            phase++;
        end
        rx_ch.valid <= 1'b0;
        calm = 1'b0;
        wait_idle();

        $display("Run covered %0d request bytes in %0d frames over %0d register settings",
                 rx_items, frames_sent, settings_used);
        $display("%0d replies predicted, %0d reply words compared", reply_count, words_checked);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- modbus_rtu_input_register_responder.f -----
design/mbrtu_pkg.sv
design/mbrtu_ifs.sv
design/mbrtu_front.sv
design/mbrtu_queue.sv
design/mbrtu_back.sv
design/modbus_rtu_input_register_responder.sv
design/mbrtu_checker.sv
sim/tb_modbus_rtu_input_register_responder.sv
